// ===== rtl/anlp_pkg.sv =====
`timescale 1ns / 1ps

package anlp_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_LENGTH_DEF = 255;

	localparam int STATUS_W = 2;
	localparam int VALUE_W  = 32;
	localparam int LENGTH_W = 8;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MALFORM  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_NUM  = 2'd2;

	// base mask bits
	localparam int BI_BIN = 0;
	localparam int BI_OCT = 1;
	localparam int BI_DEC = 2;
	localparam int BI_HEX = 3;
	localparam logic [3:0] BM_BIN = 4'b0001;
	localparam logic [3:0] BM_OCT = 4'b0010;
	localparam logic [3:0] BM_DEC = 4'b0100;
	localparam logic [3:0] BM_HEX = 4'b1000;
	localparam logic [3:0] BM_ALL = 4'b1111;
	localparam logic [3:0] BM_BIN_HEX = 4'b1001;
	localparam logic [3:0] BM_NO_BIN  = 4'b1110;
	localparam logic [3:0] BM_NO_OCT  = 4'b1101;
	localparam logic [3:0] BM_NO_DEC  = 4'b1011;

	// characters
	localparam logic [7:0] C_NUL    = 8'h00;
	localparam logic [7:0] C_DQUOTE = 8'h22;
	localparam logic [7:0] C_SQUOTE = 8'h27;
	localparam logic [7:0] C_AMP    = 8'h26;
	localparam logic [7:0] C_PCT    = 8'h25;
	localparam logic [7:0] C_DOLLAR = 8'h24;
	localparam logic [7:0] C_AT     = 8'h40;
	localparam logic [7:0] C_MINUS  = 8'h2D;
	localparam logic [7:0] C_LX     = 8'h78;
	localparam logic [7:0] C_UX     = 8'h58;
	localparam logic [7:0] C_UQ     = 8'h51;
	localparam logic [7:0] C_UO     = 8'h4F;
	localparam logic [7:0] C_UH     = 8'h48;
	localparam logic [7:0] C_UB     = 8'h42;

	typedef enum logic [3:0] {
		F_IDLE      = 4'd0,
		F_DQ0       = 4'd1,
		F_DQ1       = 4'd2,
		F_SQ        = 4'd3,
		F_PFX_FIRST = 4'd4,
		F_PFX_RUN   = 4'd5,
		F_NUM       = 4'd6,
		F_WAIT_OK   = 4'd7,
		F_WAIT_BAD  = 4'd8
	} form_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       start_req;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		form_t      form;
		logic       negative;
		logic [3:0] base_mask;
		logic       binary_closed;
		logic [7:0] high_byte;
	} ctl_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  value;
		logic                consumed;
		logic [LENGTH_W-1:0] length;
	} res_t;

	// bit 4 set when c is a hex digit, low nibble is its value
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		return r;
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? 8'(c - 8'h20) : c;
	endfunction

	function automatic logic is_sym(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h30 && c <= 8'h39) || c == 8'h5F || c == 8'h2E ||
			c == C_DOLLAR || c == C_AT || c == 8'h3F;
	endfunction

	function automatic logic is_numchar(input logic [7:0] c);
		logic [7:0] u;
		logic [4:0] hv;
		u  = to_upper(c);
		hv = hex_val(c);
		return hv[4] || u == C_UQ || u == C_UH || u == C_UO;
	endfunction

endpackage

// ===== rtl/assembler_number_literal_parser_top.sv =====
`timescale 1ns / 1ps

// Numeric term recognizer for assembler operands. Feed the operand one character per
// request, with start_req on the first character of a term; a result request appears
// once the term is decided (status, value, length, and consumed when the character
// itself closed a quote constant). The block takes one character every cycle unless
// the output stalls: each request lands in an input register, the term state (form,
// base mask and the four radix accumulators) steps combinationally from there, and
// the result sits in an output register that drives out_valid. Rate is set by the
// state loop through the accumulator update (constant-factor shift-adds only). The
// input register stalls only while a result waits in the output register and
// out_ready is low.
module assembler_number_literal_parser_top import anlp_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 ch,
	input  logic                       start_req,
	input  logic                       end_of_text,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STATUS_W-1:0]        status,
	output logic signed [VALUE_W-1:0]  value,
	output logic                       consumed,
	output logic [LENGTH_W-1:0]        length
);

	localparam int CW = $clog2(MAX_LENGTH + 1);

	// input stage
	item_t          item_s1;
	logic           valid_s1;

	// term state
	ctl_t           ctl_q;
	logic [VALUE_BITS-1:0] dec_q, bin_q, oct_q, hex_q;
	logic [CW-1:0]  count_q;

	// step outputs
	ctl_t           ctl_nxt;
	logic [VALUE_BITS-1:0] dec_nxt, bin_nxt, oct_nxt, hex_nxt;
	logic [CW-1:0]  count_nxt;
	logic           emit;
	res_t           res;

	// output register
	logic           out_valid_q;
	res_t           res_q;

	logic           out_free;
	logic           step;

	assign out_free = !out_valid_q || out_ready;
	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.ch          <= ch;
			item_s1.start_req   <= start_req;
			item_s1.end_of_text <= end_of_text;
		end
	end

	anlp_step #(
		.VB(VALUE_BITS),
		.CW(CW),
		.MAX_LENGTH(MAX_LENGTH)
	) u_step (
		.item(item_s1),
		.ctl(ctl_q),
		.dec_acc(dec_q),
		.bin_acc(bin_q),
		.oct_acc(oct_q),
		.hex_acc(hex_q),
		.char_count(count_q),
		.ctl_nxt(ctl_nxt),
		.dec_nxt(dec_nxt),
		.bin_nxt(bin_nxt),
		.oct_nxt(oct_nxt),
		.hex_nxt(hex_nxt),
		.count_nxt(count_nxt),
		.emit(emit),
		.res(res)
	);

	// term state advances once per processed character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.form          <= F_IDLE;
			ctl_q.negative      <= 1'b0;
			ctl_q.base_mask     <= BM_ALL;
			ctl_q.binary_closed <= 1'b0;
			ctl_q.high_byte     <= '0;
			dec_q   <= '0;
			bin_q   <= '0;
			oct_q   <= '0;
			hex_q   <= '0;
			count_q <= '0;
		end else if (step) begin
			ctl_q   <= ctl_nxt;
			dec_q   <= dec_nxt;
			bin_q   <= bin_nxt;
			oct_q   <= oct_nxt;
			hex_q   <= hex_nxt;
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = res_q.status;
	assign value     = res_q.value;
	assign consumed  = res_q.consumed;
	assign length    = res_q.length;

endmodule

// ===== rtl/anlp_step.sv =====
`timescale 1ns / 1ps

// One character step: next term state and the optional result.
module anlp_step import anlp_pkg::*; #(
	parameter int VB = VALUE_BITS_DEF,
	parameter int CW = 8,
	parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
	input  item_t          item,
	input  ctl_t           ctl,
	input  logic [VB-1:0]  dec_acc,
	input  logic [VB-1:0]  bin_acc,
	input  logic [VB-1:0]  oct_acc,
	input  logic [VB-1:0]  hex_acc,
	input  logic [CW-1:0]  char_count,
	output ctl_t           ctl_nxt,
	output logic [VB-1:0]  dec_nxt,
	output logic [VB-1:0]  bin_nxt,
	output logic [VB-1:0]  oct_nxt,
	output logic [VB-1:0]  hex_nxt,
	output logic [CW-1:0]  count_nxt,
	output logic           emit,
	output res_t           res
);

	logic                term;
	logic [CW-1:0]       cnt_inc;
	logic [4:0]          hv_ch;
	logic                pfx_ok;
	logic [VB-1:0]       pfx_val;
	logic [1:0]          e_st;
	logic [VB-1:0]       e_val;
	logic                e_cons;
	logic [CW-1:0]       e_len;
	logic                do_num;
	logic                in_wait;
	logic                wait_ok;
	logic [7:0]          u;
	logic [4:0]          hv_u;

	assign term    = item.end_of_text || item.ch == C_NUL;
	assign cnt_inc = (char_count < CW'(MAX_LENGTH)) ? CW'(char_count + 1'b1) : char_count;
	assign hv_ch   = hex_val(item.ch);

	// digit accepted by a prefix form
	always_comb begin
		pfx_ok = 1'b0;
		if (!term && hv_ch[4]) begin
			if (ctl.base_mask == BM_BIN)
				pfx_ok = hv_ch[3:0] <= 4'd1;
			else if (ctl.base_mask == BM_OCT)
				pfx_ok = hv_ch[3:0] <= 4'd7;
			else if (ctl.base_mask == BM_DEC)
				pfx_ok = hv_ch[3:0] <= 4'd9;
			else
				pfx_ok = 1'b1;
		end
	end

	always_comb begin
		if (ctl.base_mask == BM_BIN)
			pfx_val = bin_acc;
		else if (ctl.base_mask == BM_OCT)
			pfx_val = oct_acc;
		else if (ctl.base_mask == BM_DEC)
			pfx_val = dec_acc;
		else
			pfx_val = hex_acc;
		if (ctl.negative)
			pfx_val = VB'(0) - pfx_val;
	end

	assign u    = to_upper(item.ch);
	assign hv_u = hex_val(u);

	always_comb begin
		ctl_nxt   = ctl;
		dec_nxt   = dec_acc;
		bin_nxt   = bin_acc;
		oct_nxt   = oct_acc;
		hex_nxt   = hex_acc;
		count_nxt = char_count;
		emit      = 1'b0;
		e_st      = ST_OK;
		e_val     = '0;
		e_cons    = 1'b0;
		e_len     = char_count;
		do_num    = 1'b0;
		in_wait   = 1'b0;
		wait_ok   = 1'b0;

		if (item.start_req) begin
			ctl_nxt.form          = F_IDLE;
			ctl_nxt.negative      = 1'b0;
			ctl_nxt.base_mask     = BM_ALL;
			ctl_nxt.binary_closed = 1'b0;
			ctl_nxt.high_byte     = '0;
			dec_nxt   = '0;
			bin_nxt   = '0;
			oct_nxt   = '0;
			hex_nxt   = '0;
			count_nxt = '0;
			if (term) begin
				emit = 1'b1;
				e_st = ST_NOT_NUM;
			end else begin
				count_nxt = CW'(1);
				if (item.ch == C_DQUOTE)
					ctl_nxt.form = F_DQ0;
				else if (item.ch == C_SQUOTE)
					ctl_nxt.form = F_SQ;
				else if (item.ch == C_AMP) begin
					ctl_nxt.form = F_PFX_FIRST;
					ctl_nxt.base_mask = BM_DEC;
				end else if (item.ch == C_PCT) begin
					ctl_nxt.form = F_PFX_FIRST;
					ctl_nxt.base_mask = BM_BIN;
				end else if (item.ch == C_DOLLAR) begin
					ctl_nxt.form = F_PFX_FIRST;
					ctl_nxt.base_mask = BM_HEX;
				end else if (item.ch == C_AT) begin
					ctl_nxt.form = F_PFX_FIRST;
					ctl_nxt.base_mask = BM_OCT;
				end else if (item.ch >= 8'h30 && item.ch <= 8'h39) begin
					ctl_nxt.form = F_NUM;
					do_num = 1'b1;
				end else begin
					emit = 1'b1;
					e_st = ST_NOT_NUM;
				end
			end
		end else begin
			unique case (ctl.form)
				F_DQ0: begin
					if (term) begin
						emit = 1'b1;
						e_st = ST_MALFORM;
					end else begin
						ctl_nxt.high_byte = item.ch;
						count_nxt = cnt_inc;
						ctl_nxt.form = F_DQ1;
					end
				end
				F_DQ1, F_SQ: begin
					emit = 1'b1;
					if (term)
						e_st = ST_MALFORM;
					else begin
						count_nxt = cnt_inc;
						e_len  = cnt_inc;
						e_cons = 1'b1;
						e_val  = (ctl.form == F_DQ1) ?
							VB'({ctl.high_byte, item.ch}) : VB'(item.ch);
					end
				end
				F_PFX_FIRST, F_PFX_RUN: begin
					if (ctl.form == F_PFX_FIRST && !term && item.ch == C_MINUS &&
							char_count == CW'(1) && !ctl.negative &&
							ctl.base_mask != BM_OCT) begin
						ctl_nxt.negative = 1'b1;
						count_nxt = cnt_inc;
					end else if (pfx_ok) begin
						if (ctl.base_mask == BM_BIN)
							bin_nxt = VB'((bin_acc << 1) + VB'(hv_ch[3:0]));
						else if (ctl.base_mask == BM_OCT)
							oct_nxt = VB'((oct_acc << 3) + VB'(hv_ch[3:0]));
						else if (ctl.base_mask == BM_DEC)
							dec_nxt = VB'((dec_acc << 3) + (dec_acc << 1) +
								VB'(hv_ch[3:0]));
						else
							hex_nxt = VB'((hex_acc << 4) + VB'(hv_ch[3:0]));
						count_nxt = cnt_inc;
						ctl_nxt.form = F_PFX_RUN;
					end else if (ctl.form == F_PFX_RUN) begin
						emit  = 1'b1;
						e_st  = ST_OK;
						e_val = pfx_val;
					end else begin
						emit = 1'b1;
						// lone @ is a symbol, not a broken octal number
						e_st = (ctl.base_mask == BM_OCT && char_count == CW'(1)) ?
							ST_NOT_NUM : ST_MALFORM;
					end
				end
				F_NUM: begin
					if (!term && (item.ch == C_LX || item.ch == C_UX) &&
							char_count == CW'(1) && dec_acc == '0) begin
						ctl_nxt.base_mask = BM_HEX;
						ctl_nxt.binary_closed = 1'b0;
						count_nxt = cnt_inc;
						ctl_nxt.form = F_PFX_FIRST;
					end else if (!term && is_numchar(item.ch)) begin
						count_nxt = cnt_inc;
						do_num = 1'b1;
					end else begin
						in_wait = 1'b1;
						if (ctl.binary_closed) begin
							dec_nxt = bin_acc;
							wait_ok = 1'b1;
						end else
							wait_ok = ctl.base_mask[BI_DEC];
					end
				end
				F_WAIT_OK: begin
					in_wait = 1'b1;
					wait_ok = 1'b1;
				end
				F_WAIT_BAD: begin
					in_wait = 1'b1;
					wait_ok = 1'b0;
				end
				default: ctl_nxt.form = F_IDLE;
			endcase
		end

		// hold the decision until the trailing symbol run ends
		if (in_wait) begin
			if (!term && item.ch == C_DOLLAR) begin
				emit = 1'b1;
				e_st = ST_NOT_NUM;
			end else if (!term && is_sym(item.ch))
				ctl_nxt.form = wait_ok ? F_WAIT_OK : F_WAIT_BAD;
			else begin
				emit  = 1'b1;
				e_st  = wait_ok ? ST_OK : ST_MALFORM;
				e_val = dec_nxt;
			end
		end

		// bare digit string: all bases tracked in parallel
		if (do_num) begin
			if (ctl_nxt.binary_closed) begin
				ctl_nxt.binary_closed = 1'b0;
				ctl_nxt.base_mask = ctl_nxt.base_mask & BM_NO_BIN;
			end
			if (u == C_UQ || u == C_UO) begin
				if (ctl_nxt.base_mask[BI_OCT]) begin
					dec_nxt = oct_nxt;
					ctl_nxt.form = F_WAIT_OK;
				end else
					ctl_nxt.form = F_WAIT_BAD;
			end else if (u == C_UH) begin
				if (ctl_nxt.base_mask[BI_HEX]) begin
					dec_nxt = hex_nxt;
					ctl_nxt.form = F_WAIT_OK;
				end else
					ctl_nxt.form = F_WAIT_BAD;
			end else begin
				if (u == C_UB && ctl_nxt.base_mask[BI_BIN]) begin
					ctl_nxt.binary_closed = 1'b1;
					ctl_nxt.base_mask = BM_BIN_HEX;
				end
				if (ctl_nxt.base_mask[BI_HEX])
					hex_nxt = VB'((hex_nxt << 4) + VB'(hv_u[3:0]));
				if (ctl_nxt.base_mask[BI_DEC]) begin
					if (hv_u[3:0] > 4'd9)
						ctl_nxt.base_mask = ctl_nxt.base_mask & BM_NO_DEC;
					else
						dec_nxt = VB'((dec_nxt << 3) + (dec_nxt << 1) + VB'(hv_u[3:0]));
				end
				if (ctl_nxt.base_mask[BI_OCT]) begin
					if (hv_u[3:0] > 4'd7)
						ctl_nxt.base_mask = ctl_nxt.base_mask & BM_NO_OCT;
					else
						oct_nxt = VB'((oct_nxt << 3) + VB'(hv_u[3:0]));
				end
				if (ctl_nxt.base_mask[BI_BIN]) begin
					if (hv_u[3:0] > 4'd1)
						ctl_nxt.base_mask = ctl_nxt.base_mask & BM_NO_BIN;
					else
						bin_nxt = VB'((bin_nxt << 1) + VB'(hv_u[3:0]));
				end
				if (ctl_nxt.base_mask == 4'b0000)
					ctl_nxt.form = F_WAIT_BAD;
			end
		end

		if (emit)
			ctl_nxt.form = F_IDLE;
	end

	assign res.status   = e_st;
	assign res.value    = (e_st == ST_OK) ? VALUE_W'(e_val) : '0;
	assign res.consumed = e_cons;
	assign res.length   = (e_st == ST_NOT_NUM) ? '0 : LENGTH_W'(e_len);

endmodule

// ===== test/number_term_checker.sv =====
`timescale 1ns / 1ps

module number_term_checker import anlp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [7:0]                ch,
	input  logic                      start_req,
	input  logic                      end_of_text,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [STATUS_W-1:0]       status,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      consumed,
	input  logic [LENGTH_W-1:0]       length,
	output int                        fail_count,
	output int                        outstanding
);

	// shadow of the term state
	form_t               t_form;
	logic                t_neg;
	logic [VALUE_W-1:0]  acc_dec, acc_bin, acc_oct, acc_hex;
	logic [3:0]          t_bases;
	logic                t_bin_closed;
	logic [7:0]          t_hi_byte;
	logic [LENGTH_W-1:0] t_len;

	res_t term_results_q[$];
	res_t want;
	int   mismatches;

	function automatic int digit_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		return -1;
	endfunction

	function automatic logic symbol_char(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
			c == "_" || c == "." || c == C_DOLLAR || c == C_AT || c == "?";
	endfunction

	// digits plus the Q/O/H suffix letters
	function automatic logic number_char(input logic [7:0] c);
		return digit_of(c) >= 0 || c == "q" || c == "h" || c == "o" ||
			c == C_UQ || c == C_UH || c == C_UO;
	endfunction

	function automatic int radix_digit(input logic [7:0] c, input logic [3:0] bases);
		int d;
		d = digit_of(c);
		if (d < 0) return -1;
		case (bases)
		BM_BIN: return (d <= 1) ? d : -1;
		BM_OCT: return (d <= 7) ? d : -1;
		BM_DEC: return (d <= 9) ? d : -1;
		default: return d;
		endcase
	endfunction

	function automatic logic [VALUE_W-1:0] prefix_number();
		logic [VALUE_W-1:0] v;
		case (t_bases)
		BM_BIN: v = acc_bin;
		BM_OCT: v = acc_oct;
		BM_DEC: v = acc_dec;
		default: v = acc_hex;
		endcase
		return t_neg ? -v : v;
	endfunction

	task automatic clear_term();
		t_form       = F_IDLE;
		t_neg        = 1'b0;
		acc_dec      = '0;
		acc_bin      = '0;
		acc_oct      = '0;
		acc_hex      = '0;
		t_bases      = BM_ALL;
		t_bin_closed = 1'b0;
		t_hi_byte    = '0;
		t_len        = '0;
	endtask

	task automatic count_char();
		if (t_len < MAX_LENGTH_DEF)
			t_len++;
	endtask

	task automatic close_term(input logic [STATUS_W-1:0] st, input logic [VALUE_W-1:0] v,
		input logic cons);
		res_t r;
		r.status   = st;
		r.value    = (st == ST_OK) ? v : '0;
		r.consumed = cons;
		r.length   = (st == ST_NOT_NUM) ? '0 : t_len;
		term_results_q.push_back(r);
		t_form = F_IDLE;
	endtask

	task automatic prefix_shift_in(input int d);
		logic [VALUE_W-1:0] dv;
		dv = VALUE_W'(d);
		case (t_bases)
		BM_BIN: acc_bin = acc_bin * 2 + dv;
		BM_OCT: acc_oct = acc_oct * 8 + dv;
		BM_DEC: acc_dec = acc_dec * 10 + dv;
		default: acc_hex = acc_hex * 16 + dv;
		endcase
	endtask

	// one digit or suffix of a bare number; all live radices advance together
	task automatic bare_char(input logic [7:0] c);
		logic [7:0]         u;
		logic [VALUE_W-1:0] d;
		u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
		if (t_bin_closed) begin
			t_bin_closed = 1'b0;
			t_bases &= BM_NO_BIN;
		end
		if (u == C_UQ || u == C_UO) begin
			if (t_bases[BI_OCT]) begin
				acc_dec = acc_oct;
				t_form  = F_WAIT_OK;
			end else
				t_form = F_WAIT_BAD;
		end else if (u == C_UH) begin
			if (t_bases[BI_HEX]) begin
				acc_dec = acc_hex;
				t_form  = F_WAIT_OK;
			end else
				t_form = F_WAIT_BAD;
		end else begin
			// a B may still be a hex digit, so binary is only closed tentatively
			if (u == C_UB && t_bases[BI_BIN]) begin
				t_bin_closed = 1'b1;
				t_bases      = BM_BIN_HEX;
			end
			d = VALUE_W'(digit_of(u));
			if (t_bases[BI_HEX])
				acc_hex = acc_hex * 16 + d;
			if (t_bases[BI_DEC]) begin
				if (d > 9) t_bases &= BM_NO_DEC;
				else acc_dec = acc_dec * 10 + d;
			end
			if (t_bases[BI_OCT]) begin
				if (d > 7) t_bases &= BM_NO_OCT;
				else acc_oct = acc_oct * 8 + d;
			end
			if (t_bases[BI_BIN]) begin
				if (d > 1) t_bases &= BM_NO_BIN;
				else acc_bin = acc_bin * 2 + d;
			end
			if (t_bases == 4'd0)
				t_form = F_WAIT_BAD;
		end
	endtask

	task automatic open_term(input logic [7:0] c, input logic stop);
		clear_term();
		if (stop)
			close_term(ST_NOT_NUM, '0, 1'b0);
		else begin
			count_char();
			case (c)
			C_DQUOTE: t_form = F_DQ0;
			C_SQUOTE: t_form = F_SQ;
			C_AMP: begin
				t_form  = F_PFX_FIRST;
				t_bases = BM_DEC;
			end
			C_PCT: begin
				t_form  = F_PFX_FIRST;
				t_bases = BM_BIN;
			end
			C_DOLLAR: begin
				t_form  = F_PFX_FIRST;
				t_bases = BM_HEX;
			end
			C_AT: begin
				t_form  = F_PFX_FIRST;
				t_bases = BM_OCT;
			end
			default: begin
				if (c >= "0" && c <= "9") begin
					t_form = F_NUM;
					bare_char(c);
				end else
					close_term(ST_NOT_NUM, '0, 1'b0);
			end
			endcase
		end
	endtask

	// bare number is done; symbol chars keep it pending, a $ turns it into a symbol
	task automatic settle_wait(input logic [7:0] c, input logic stop);
		if (!stop && c == C_DOLLAR)
			close_term(ST_NOT_NUM, '0, 1'b0);
		else if (stop || !symbol_char(c)) begin
			if (t_form == F_WAIT_OK) close_term(ST_OK, acc_dec, 1'b0);
			else close_term(ST_MALFORM, '0, 1'b0);
		end
	endtask

	task automatic predict_term_step(input logic [7:0] c, input logic s, input logic e);
		logic stop;
		int   d;
		stop = e || c == C_NUL;
		if (s)
			open_term(c, stop);
		else begin
			case (t_form)
			F_DQ0: begin
				if (stop) close_term(ST_MALFORM, '0, 1'b0);
				else begin
					t_hi_byte = c;
					count_char();
					t_form = F_DQ1;
				end
			end
			F_DQ1: begin
				if (stop) close_term(ST_MALFORM, '0, 1'b0);
				else begin
					count_char();
					close_term(ST_OK, {16'd0, t_hi_byte, c}, 1'b1);
				end
			end
			F_SQ: begin
				if (stop) close_term(ST_MALFORM, '0, 1'b0);
				else begin
					count_char();
					close_term(ST_OK, {24'd0, c}, 1'b1);
				end
			end
			F_PFX_FIRST: begin
				if (!stop && c == C_MINUS && t_len == 8'd1 && !t_neg && t_bases != BM_OCT) begin
					t_neg = 1'b1;
					count_char();
				end else begin
					d = stop ? -1 : radix_digit(c, t_bases);
					if (d >= 0) begin
						prefix_shift_in(d);
						count_char();
						t_form = F_PFX_RUN;
					end else if (t_bases == BM_OCT && t_len == 8'd1)
						close_term(ST_NOT_NUM, '0, 1'b0);
					else
						close_term(ST_MALFORM, '0, 1'b0);
				end
			end
			F_PFX_RUN: begin
				d = stop ? -1 : radix_digit(c, t_bases);
				if (d >= 0) begin
					prefix_shift_in(d);
					count_char();
				end else
					close_term(ST_OK, prefix_number(), 1'b0);
			end
			F_NUM: begin
				if (!stop && (c == C_LX || c == C_UX) && t_len == 8'd1 && acc_dec == '0) begin
					t_bases      = BM_HEX;
					t_bin_closed = 1'b0;
					count_char();
					t_form = F_PFX_FIRST;
				end else if (!stop && number_char(c)) begin
					count_char();
					bare_char(c);
				end else begin
					if (t_bin_closed) begin
						acc_dec = acc_bin;
						t_form  = F_WAIT_OK;
					end else if (t_bases[BI_DEC])
						t_form = F_WAIT_OK;
					else
						t_form = F_WAIT_BAD;
					settle_wait(c, stop);
				end
			end
			F_WAIT_OK, F_WAIT_BAD: settle_wait(c, stop);
			default: t_form = F_IDLE;
			endcase
		end
	endtask

	task automatic flag_mismatch(input string what);
		$display("%0t: term result mismatch: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_term();
			term_results_q.delete();
			mismatches = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_term_step(ch, start_req, end_of_text);
			if (out_valid && out_ready) begin
				if (term_results_q.size() == 0)
					flag_mismatch("result with no term pending");
				else begin
					want = term_results_q.pop_front();
					if (status !== want.status)
						flag_mismatch($sformatf("status %0d, expected %0d", status, want.status));
					if (value !== want.value)
						flag_mismatch($sformatf("value %h, expected %h", value, want.value));
					if (consumed !== want.consumed)
						flag_mismatch($sformatf("consumed %b, expected %b", consumed,
							want.consumed));
					if (length !== want.length)
						flag_mismatch($sformatf("length %0d, expected %0d", length, want.length));
				end
			end
			fail_count  <= mismatches;
			outstanding <= term_results_q.size();
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import anlp_pkg::*;

	// stop once this many random-phase characters have gone in, noise included
	localparam int TERM_ITEMS  = 1550;
	// cycles with no request moving on either side before we call it hung
	localparam int STALL_LIMIT = 1000;
	// tail codes for queue_term
	localparam int TAIL_EOT    = -1;
	localparam int TAIL_NONE   = -2;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [7:0]                ch;
	logic                      start_req;
	logic                      end_of_text;
	logic                      out_valid;
	logic                      out_ready;
	logic [STATUS_W-1:0]       status;
	logic signed [VALUE_W-1:0] value;
	logic                      consumed;
	logic [LENGTH_W-1:0]       length;

	int          fail_count;
	int          outstanding;
	bit          idling_on;
	int unsigned hold_cnt;
	int          quiet_cnt;
	int          sent_items;
	int          term_no;
	item_t       text_q[$];

	assembler_number_literal_parser_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.ch          (ch),
		.start_req   (start_req),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.value       (value),
		.consumed    (consumed),
		.length      (length)
	);

	// predicts every result from the accepted requests and compares in order
	number_term_checker term_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.ch          (ch),
		.start_req   (start_req),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.value       (value),
		.consumed    (consumed),
		.length      (length),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side: random back-pressure bursts while idling is on
	always @(posedge clk) begin
		if (hold_cnt != 0)
			hold_cnt--;
		else if (idling_on && $urandom_range(0, 7) == 0)
			hold_cnt = $urandom_range(1, 6);
		out_ready <= (hold_cnt == 0);
	end

	// watchdog: any request moving on either channel resets the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cnt = 0;
		else begin
			quiet_cnt++;
			if (quiet_cnt >= STALL_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	function automatic logic [7:0] pick_digit(input int radix);
		int d;
		d = $urandom_range(0, radix - 1);
		if (d < 10)
			return 8'("0" + d);
		return $urandom_range(0, 1) ? 8'("A" + d - 10) : 8'("a" + d - 10);
	endfunction

	task automatic queue_char(input logic [7:0] c, input logic s, input logic e);
		item_t it;
		it.ch          = c;
		it.start_req   = s;
		it.end_of_text = e;
		text_q.push_back(it);
	endtask

	// first char of body opens the term; tail is a closing char, end of text, or nothing
	task automatic queue_term(input string body, input int tail);
		for (int i = 0; i < body.len(); i++)
			queue_char(body[i], i == 0, 1'b0);
		if (tail == TAIL_EOT)
			queue_char(8'($urandom), 1'b0, 1'b1);
		else if (tail != TAIL_NONE)
			queue_char(8'(tail), 1'b0, 1'b0);
	endtask

	// One request: optional idle burst first, then hold valid until accepted.
	// in_ready is sampled at the edge, before the block updates it.
	task automatic send_char(input item_t it);
		if (idling_on && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		ch          <= it.ch;
		start_req   <= it.start_req;
		end_of_text <= it.end_of_text;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic flush_text();
		while (text_q.size() != 0)
			send_char(text_q.pop_front());
	endtask

	// drop valid and wait for every predicted result; outstanding is a registered copy
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Builds one random term, mostly well-formed with random content, plus a
	// terminator. Two terms run past the 255-character length ceiling.
	task automatic queue_random_term(input int n_term);
		int         kind, n, radix, first;
		logic [7:0] lead;
		bit         noise, force_stop;
		string      sfx, tails, syms, specials;
		sfx        = "QqOoHhBb";
		tails      = " ,+);-";
		syms       = "_.?@gZx9";
		specials   = "*.<>";
		noise      = 1'b0;
		force_stop = 1'b0;
		first      = text_q.size();
		kind       = $urandom_range(0, 99);
		if (n_term == 3 || n_term == 140) begin
			queue_char($urandom_range(0, 1) ? C_AMP : 8'("7"), 1'b1, 1'b0);
			repeat ($urandom_range(256, 270))
				queue_char(pick_digit(10), 1'b0, 1'b0);
		end else if (kind < 18) begin
			// prefixed: & % $ @, optional minus, sometimes a stray digit
			case ($urandom_range(0, 3))
			0: begin lead = C_AMP; radix = 10; end
			1: begin lead = C_PCT; radix = 2; end
			2: begin lead = C_DOLLAR; radix = 16; end
			default: begin lead = C_AT; radix = 8; end
			endcase
			queue_char(lead, 1'b1, 1'b0);
			if ($urandom_range(0, 2) == 0)
				queue_char(C_MINUS, 1'b0, 1'b0);
			n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
			repeat (n)
				queue_char(($urandom_range(0, 14) == 0) ? pick_digit(16) : pick_digit(radix),
					1'b0, 1'b0);
		end else if (kind < 26) begin
			queue_char("0", 1'b1, 1'b0);
			queue_char($urandom_range(0, 1) ? C_LX : C_UX, 1'b0, 1'b0);
			repeat ($urandom_range(0, 8))
				queue_char(pick_digit(16), 1'b0, 1'b0);
		end else if (kind < 34) begin
			// quote constants, now and then cut short by end of text
			if ($urandom_range(0, 1)) begin
				queue_char(C_SQUOTE, 1'b1, 1'b0);
				n = 1;
			end else begin
				queue_char(C_DQUOTE, 1'b1, 1'b0);
				n = 2;
			end
			if ($urandom_range(0, 6) == 0) begin
				n = $urandom_range(0, n - 1);
				force_stop = 1'b1;
			end
			repeat (n)
				queue_char(8'($urandom), 1'b0, 1'b0);
		end else if (kind < 70) begin
			// bare digits from one radix family, optional suffix, trailing symbol chars
			case ($urandom_range(0, 3))
			0: radix = 2;
			1: radix = 8;
			2: radix = 10;
			default: radix = 16;
			endcase
			queue_char(pick_digit((radix < 10) ? radix : 10), 1'b1, 1'b0);
			repeat ($urandom_range(0, 9))
				queue_char(pick_digit(radix), 1'b0, 1'b0);
			if ($urandom_range(0, 2) != 0)
				queue_char(sfx[$urandom_range(0, 7)], 1'b0, 1'b0);
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					queue_char(($urandom_range(0, 5) == 0) ? C_DOLLAR : syms[$urandom_range(0, 7)],
						1'b0, 1'b0);
		end else if (kind < 82) begin
			case ($urandom_range(0, 5))
			0, 1, 2, 3: lead = specials[$urandom_range(0, 3)];
			4: lead = 8'("a" + $urandom_range(0, 25));
			default: lead = 8'($urandom);
			endcase
			queue_char(lead, 1'b1, 1'b0);
		end else begin
			// noise: random bytes, stray starts and ends of text
			noise = 1'b1;
			repeat ($urandom_range(1, 4))
				queue_char(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
		end
		if (force_stop)
			queue_char(($urandom_range(0, 1)) ? C_NUL : 8'($urandom), 1'b0, 1'b1);
		else if (!noise) begin
			case ($urandom_range(0, 9))
			0, 1, 2: queue_char(tails[$urandom_range(0, 5)], 1'b0, 1'b0);
			3, 4: queue_char(8'($urandom), 1'b0, 1'b1);
			5: queue_char(C_NUL, 1'b0, 1'b0);
			6, 7: ; // next term's start cuts this one off
			default: queue_char(8'($urandom), 1'b0, 1'b0);
			endcase
		end
		sent_items += text_q.size() - first;
	endtask

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		ch          <= '0;
		start_req   <= 1'b0;
		end_of_text <= 1'b0;
		out_ready   <= 1'b0;
		idling_on   = 1'b1;
		sent_items  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed terms
		queue_term("&-12", C_NUL);           // negative decimal, NUL ends it
		queue_term("$fF", " ");              // mixed-case hex
		queue_term("0x", TAIL_EOT);          // prefix with no digits
		queue_char(C_SQUOTE, 1'b1, 1'b0);    // quote of the top byte
		queue_char(8'hFF, 1'b0, 1'b0);
		queue_term("\"", TAIL_EOT);          // quote byte missing
		queue_term("19b", ",");              // binary suffix no longer possible
		queue_term("7$", TAIL_NONE);         // dollar in a digit run: symbol
		queue_char(8'h80, 1'b1, 1'b1);       // empty start
		queue_term("1", TAIL_NONE);          // left open, then restarted below
		queue_term("@9", TAIL_NONE);         // @ without an octal digit
		queue_term("*", TAIL_NONE);          // special
		queue_char("5", 1'b0, 1'b0);         // no term open: ignored
		queue_term("\"ab", TAIL_NONE);       // two-char constant closes itself
		flush_text();

		// hold the sender off until everything predicted so far is back
		drain_results();

		// random terms; idling switched off in some stretches and at the end
		term_no = 0;
		while (sent_items < TERM_ITEMS) begin
			idling_on = (sent_items < TERM_ITEMS - 250) && (term_no % 40 < 28);
			queue_random_term(term_no);
			flush_text();
			term_no++;
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ===== assembler_number_literal_parser_top.f =====
rtl/anlp_pkg.sv
rtl/anlp_step.sv
rtl/assembler_number_literal_parser_top.sv
test/number_term_checker.sv
test/tb.sv
